>>> rtl/core/sha1md_pkg.sv
// Shared types and constants of the SHA-1 message digest core.
// No dependencies; every other file of the core imports this package.
package sha1md_pkg;

	localparam int unsigned WORD_W       = 32;
	localparam int unsigned DIGEST_WORDS = 5;
	localparam int unsigned BLOCK_BITS   = 512;
	localparam int unsigned SCHED_WORDS  = 16;
	localparam int unsigned ROUNDS       = 80;
	localparam int unsigned FIFO_DEPTH   = 4;
	localparam int unsigned FILL_W       = 6;
	localparam int unsigned IDX_W        = 3;

	localparam logic [FILL_W-1:0] FILL_MAX = 6'd63;
	localparam logic [FILL_W-1:0] LEN_POS  = 6'd56;
	localparam logic [7:0]        PAD_BYTE = 8'h80;
	localparam logic [IDX_W-1:0]  IDX_LAST = 3'd4;

	typedef logic [DIGEST_WORDS-1:0][WORD_W-1:0] digest_t;

	localparam digest_t SHA1_IV = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
	localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
	localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
	localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] digest_word;
		logic [IDX_W-1:0]  word_index;
		logic              last_word;
	} out_item_t;

	typedef struct packed {
		logic valid;
		logic last_blk;
	} blk_req_t;

	typedef enum logic [1:0] {
		ABS_RUN,
		ABS_MARK,
		ABS_PAD,
		ABS_LEN
	} abs_state_t;

	typedef enum logic [1:0] {
		RND_IDLE,
		RND_RUN,
		RND_ADD
	} rnd_state_t;

endpackage

>>> rtl/core/sha1_message_digest_core.sv
// Top level of the SHA-1 message digest core.
// Depends on sha1md_pkg, sha1md_front, sha1md_absorb, sha1md_round and sha1md_outq.
//
// Bytes go in one beat at a time; a beat with is_last closes the message and five digest
// beats follow, h0 first. The block assembler fills the next block while the round engine
// works. Each 64-byte block holds the round engine for its load, 80 rounds and chaining add.
// Closing a message adds the padding and length bytes (9 to 72) and then the last block
// before the digest appears. The digest stage holds one digest; the next message is
// absorbed meanwhile and its final block waits for it.
module sha1_message_digest_core #(
	parameter int unsigned FIFO_DEPTH = sha1md_pkg::FIFO_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  sha1md_pkg::in_item_t  item,
	output logic                  empty,
	input  logic                  pop,
	output sha1md_pkg::out_item_t result
);
	import sha1md_pkg::*;

	in_item_t              cmd;
	logic                  cmd_valid;
	logic                  cmd_take;
	blk_req_t              blk;
	logic [BLOCK_BITS-1:0] blk_data;
	logic                  blk_ready;
	logic                  dig_valid;
	logic                  dig_ready;
	digest_t               dig_words;

	sha1md_front #(
		.DEPTH(FIFO_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cmd_valid(cmd_valid),
		.cmd_take (cmd_take),
		.cmd      (cmd)
	);

	sha1md_absorb u_absorb (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_take (cmd_take),
		.cmd      (cmd),
		.blk_ready(blk_ready),
		.blk      (blk),
		.blk_data (blk_data)
	);

	sha1md_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.blk      (blk),
		.blk_data (blk_data),
		.blk_ready(blk_ready),
		.dig_ready(dig_ready),
		.dig_valid(dig_valid),
		.dig_words(dig_words)
	);

	sha1md_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.dig_valid(dig_valid),
		.dig_words(dig_words),
		.dig_ready(dig_ready),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n) blk.valid |-> blk_ready)
		else $error("block handed over while round engine busy");

	assert property (@(posedge clk) disable iff (!arst_n) dig_valid |-> dig_ready)
		else $error("digest loaded over a digest still being read");

	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.last_word) |-> (result.word_index == IDX_LAST))
		else $error("last word flag on wrong digest word");

	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && result.last_word) |=> empty)
		else $error("digest stage not drained after final word");
`endif

endmodule

>>> rtl/core/sha1md_front.sv
// Input queue of the SHA-1 core: takes beats, drops those with no effect.
// Depends on sha1md_pkg.
module sha1md_front #(
	parameter int unsigned DEPTH = sha1md_pkg::FIFO_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  sha1md_pkg::in_item_t item,
	output logic                 cmd_valid,
	input  logic                 cmd_take,
	output sha1md_pkg::in_item_t cmd
);
	import sha1md_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	in_item_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             keep;
	logic             take;

	assign full      = cnt_q == CNT_W'(DEPTH);
	assign cmd_valid = cnt_q != '0;
	assign cmd       = mem_q[rd_ptr_q];
	assign keep      = push && !full && (item.has_byte || item.is_last);
	assign take      = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (keep) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (keep) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (keep && !take) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (take && !keep) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/sha1md_absorb.sv
// Block assembler of the SHA-1 core: gathers bytes, counts bits and appends padding.
// Depends on sha1md_pkg; hands full blocks to sha1md_round.
module sha1md_absorb (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cmd_valid,
	output logic                             cmd_take,
	input  sha1md_pkg::in_item_t             cmd,
	input  logic                             blk_ready,
	output sha1md_pkg::blk_req_t             blk,
	output logic [sha1md_pkg::BLOCK_BITS-1:0] blk_data
);
	import sha1md_pkg::*;

	abs_state_t          state_q;
	abs_state_t          state_d;
	logic [BLOCK_BITS-9:0] buf_q;
	logic [FILL_W-1:0]   fill_q;
	logic [FILL_W-1:0]   fill_inc;
	logic [63:0]         bits_q;
	logic [63:0]         len_q;
	logic                can_push;
	logic                push_en;
	logic [7:0]          push_val;
	logic                load_len;

	assign fill_inc = fill_q + 1'b1;
	assign can_push = (fill_q != FILL_MAX) || blk_ready;
	assign blk_data = {buf_q, push_val};

	always_comb begin
		state_d  = state_q;
		push_en  = 1'b0;
		push_val = '0;
		cmd_take = 1'b0;
		load_len = 1'b0;
		unique case (state_q)
			ABS_RUN: begin
				if (cmd_valid && can_push) begin
					cmd_take = 1'b1;
					push_en  = cmd.has_byte;
					push_val = cmd.data_byte;
					if (cmd.is_last) begin
						load_len = 1'b1;
						state_d  = ABS_MARK;
					end
				end
			end
			ABS_MARK: begin
				if (can_push) begin
					push_en  = 1'b1;
					push_val = PAD_BYTE;
					state_d  = (fill_inc == LEN_POS) ? ABS_LEN : ABS_PAD;
				end
			end
			ABS_PAD: begin
				if (can_push) begin
					push_en = 1'b1;
					if (fill_inc == LEN_POS) begin
						state_d = ABS_LEN;
					end
				end
			end
			ABS_LEN: begin
				if (can_push) begin
					push_en  = 1'b1;
					push_val = len_q[63:56];
					if (fill_q == FILL_MAX) begin
						state_d = ABS_RUN;
					end
				end
			end
			default: state_d = ABS_RUN;
		endcase
		blk.valid    = push_en && (fill_q == FILL_MAX);
		blk.last_blk = state_q == ABS_LEN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ABS_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			bits_q <= '0;
		end else begin
			if (push_en) begin
				fill_q <= fill_inc;
			end
			if (load_len) begin
				bits_q <= '0;
			end else if (push_en && state_q == ABS_RUN) begin
				bits_q <= bits_q + 64'd8;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			buf_q <= {buf_q[BLOCK_BITS-17:0], push_val};
		end
		if (load_len) begin
			len_q <= bits_q + (cmd.has_byte ? 64'd8 : 64'd0);
		end else if (push_en && state_q == ABS_LEN) begin
			len_q <= {len_q[55:0], 8'h00};
		end
	end

endmodule

>>> rtl/core/sha1md_round.sv
// Compression engine of the SHA-1 core: one round per cycle, rolling schedule.
// Depends on sha1md_pkg; fed by sha1md_absorb, feeds sha1md_outq.
module sha1md_round (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sha1md_pkg::blk_req_t              blk,
	input  logic [sha1md_pkg::BLOCK_BITS-1:0] blk_data,
	output logic                              blk_ready,
	input  logic                              dig_ready,
	output logic                              dig_valid,
	output sha1md_pkg::digest_t               dig_words
);
	import sha1md_pkg::*;

	localparam int unsigned ROUND_W = $clog2(ROUNDS);

	rnd_state_t        state_q;
	rnd_state_t        state_d;
	digest_t           chain_q;
	digest_t           work_q;
	logic [WORD_W-1:0] sched_q [SCHED_WORDS];
	logic [ROUND_W-1:0] round_q;
	logic              last_q;
	logic [WORD_W-1:0] f;
	logic [WORD_W-1:0] k;
	logic [WORD_W-1:0] tmp;
	logic [WORD_W-1:0] mix;
	logic [WORD_W-1:0] new_w;
	logic [WORD_W-1:0] a, b, c, d, e;

	assign a = work_q[0];
	assign b = work_q[1];
	assign c = work_q[2];
	assign d = work_q[3];
	assign e = work_q[4];

	assign mix   = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
	assign new_w = {mix[WORD_W-2:0], mix[WORD_W-1]};
	assign tmp   = {a[WORD_W-6:0], a[WORD_W-1:WORD_W-5]} + f + e + k + sched_q[0];

	always_comb begin
		if (round_q < ROUND_W'(20)) begin
			f = (b & c) | (~b & d);
			k = K0;
		end else if (round_q < ROUND_W'(40)) begin
			f = b ^ c ^ d;
			k = K1;
		end else if (round_q < ROUND_W'(60)) begin
			f = (b & c) | (b & d) | (c & d);
			k = K2;
		end else begin
			f = b ^ c ^ d;
			k = K3;
		end
	end

	always_comb begin
		for (int i = 0; i < DIGEST_WORDS; i++) begin
			dig_words[i] = chain_q[i] + work_q[i];
		end
	end

	assign blk_ready = state_q == RND_IDLE;
	assign dig_valid = (state_q == RND_ADD) && last_q && dig_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			RND_IDLE: begin
				if (blk.valid) begin
					state_d = RND_RUN;
				end
			end
			RND_RUN: begin
				if (round_q == ROUND_W'(ROUNDS - 1)) begin
					state_d = RND_ADD;
				end
			end
			RND_ADD: begin
				if (!last_q || dig_ready) begin
					state_d = RND_IDLE;
				end
			end
			default: state_d = RND_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RND_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= SHA1_IV;
			round_q <= '0;
		end else begin
			if (state_q == RND_IDLE && blk.valid) begin
				round_q <= '0;
			end else if (state_q == RND_RUN) begin
				round_q <= round_q + 1'b1;
			end
			if (state_q == RND_ADD) begin
				if (!last_q) begin
					chain_q <= dig_words;
				end else if (dig_ready) begin
					chain_q <= SHA1_IV;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == RND_IDLE && blk.valid) begin
			for (int i = 0; i < SCHED_WORDS; i++) begin
				sched_q[i] <= blk_data[BLOCK_BITS-1-WORD_W*i -: WORD_W];
			end
			work_q <= chain_q;
			last_q <= blk.last_blk;
		end else if (state_q == RND_RUN) begin
			for (int i = 0; i < SCHED_WORDS - 1; i++) begin
				sched_q[i] <= sched_q[i+1];
			end
			sched_q[SCHED_WORDS-1] <= new_w;
			work_q[4] <= d;
			work_q[3] <= c;
			work_q[2] <= {b[1:0], b[WORD_W-1:2]};
			work_q[1] <= a;
			work_q[0] <= tmp;
		end
	end

endmodule

>>> rtl/core/sha1md_outq.sv
// Result stage of the SHA-1 core: holds one digest and hands it out word by word.
// Depends on sha1md_pkg; loaded by sha1md_round.
module sha1md_outq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  dig_valid,
	input  sha1md_pkg::digest_t   dig_words,
	output logic                  dig_ready,
	output logic                  empty,
	input  logic                  pop,
	output sha1md_pkg::out_item_t result
);
	import sha1md_pkg::*;

	digest_t          words_q;
	logic [IDX_W-1:0] idx_q;
	logic             busy_q;

	assign dig_ready          = !busy_q;
	assign empty              = !busy_q;
	assign result.digest_word = words_q[0];
	assign result.word_index  = idx_q;
	assign result.last_word   = idx_q == IDX_LAST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (dig_valid) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (pop && busy_q) begin
			if (idx_q == IDX_LAST) begin
				busy_q <= 1'b0;
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dig_valid) begin
			words_q <= dig_words;
		end else if (pop && busy_q) begin
			for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
				words_q[i] <= words_q[i+1];
			end
		end
	end

endmodule

>>> dv/tb_top.sv
// Testbench for sha1_message_digest_core: byte beats in, five digest words per message out.
// Depends on sha1md_pkg; a scoreboard class predicts each digest from the accepted beats.
module tb_top;
	import sha1md_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned TAIL_CYCLES = 200;
	localparam int unsigned ITEM_GOAL   = 210;
	localparam int unsigned MSG_GOAL    = 6;

	class digest_scoreboard;
		logic [WORD_W-1:0] chain[DIGEST_WORDS];
		logic [7:0]        blk[64];
		int unsigned       fill;
		logic [63:0]       msg_bits;
		out_item_t         expected_words[$];
		int unsigned       mismatches;
		int unsigned       digests_seen;
		int unsigned       words_checked;

		function new();
			restart();
			mismatches = 0;
			digests_seen = 0;
			words_checked = 0;
		endfunction

		function void restart();
			for (int i = 0; i < DIGEST_WORDS; i++)
				chain[i] = SHA1_IV[i];
			fill = 0;
			msg_bits = '0;
		endfunction

		function void compress_block();
			logic [WORD_W-1:0] w[16];
			logic [WORD_W-1:0] a, b, c, d, e, f, k, x, tmp;
			int unsigned slot;
			for (int t = 0; t < 16; t++)
				w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			e = chain[4];
			for (int r = 0; r < ROUNDS; r++) begin
				slot = r & 15;
				if (r >= 16) begin
					x = w[(r+13)&15] ^ w[(r+8)&15] ^ w[(r+2)&15] ^ w[slot];
					w[slot] = {x[30:0], x[31]};
				end
				if (r < 20) begin
					f = (b & c) | (~b & d);
					k = K0;
				end else if (r < 40) begin
					f = b ^ c ^ d;
					k = K1;
				end else if (r < 60) begin
					f = (b & c) | (b & d) | (c & d);
					k = K2;
				end else begin
					f = b ^ c ^ d;
					k = K3;
				end
				tmp = {a[26:0], a[31:27]} + f + e + k + w[slot];
				e = d;
				d = c;
				c = {b[1:0], b[31:2]};
				b = a;
				a = tmp;
			end
			chain[0] = chain[0] + a;
			chain[1] = chain[1] + b;
			chain[2] = chain[2] + c;
			chain[3] = chain[3] + d;
			chain[4] = chain[4] + e;
		endfunction

		function void absorb_byte(logic [7:0] v);
			blk[fill] = v;
			fill++;
			if (fill == 64) begin
				compress_block();
				fill = 0;
			end
		endfunction

		function void note_beat(in_item_t it);
			logic [63:0] len;
			out_item_t   w;
			if (it.has_byte) begin
				absorb_byte(it.data_byte);
				msg_bits = msg_bits + 64'd8;
			end
			if (!it.is_last)
				return;
			len = msg_bits;
			absorb_byte(PAD_BYTE);
			while (fill != LEN_POS)
				absorb_byte(8'h00);
			for (int i = 7; i >= 0; i--)
				absorb_byte(len[8*i +: 8]);
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				w.digest_word = chain[i];
				w.word_index  = IDX_W'(i);
				w.last_word   = (i == DIGEST_WORDS - 1);
				expected_words.insert(expected_words.size(), w);
			end
			digests_seen++;
			restart();
		endfunction

		task report(string msg);
			$display("tb: mismatch: %s", msg);
			mismatches++;
		endtask

		task check_word(out_item_t got);
			out_item_t want;
			if (expected_words.size() == 0) begin
				report($sformatf("unexpected digest beat %h", got));
				return;
			end
			want = expected_words.pop_front();
			words_checked++;
			if (got.digest_word !== want.digest_word)
				report($sformatf("digest_word %h, want %h (index %0d)",
					got.digest_word, want.digest_word, want.word_index));
			if (got.word_index !== want.word_index)
				report($sformatf("word_index %0d, want %0d", got.word_index, want.word_index));
			if (got.last_word !== want.last_word)
				report($sformatf("last_word %b, want %b (index %0d)",
					got.last_word, want.last_word, want.word_index));
		endtask

		function int unsigned pending();
			return expected_words.size();
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  item;
	logic      empty;
	logic      pop;
	out_item_t result;

	digest_scoreboard sb;
	int unsigned      cycle_count;
	int unsigned      beats_sent;
	int unsigned      longest_msg;
	bit               quiet_send;
	bit               quiet_recv;

	sha1_message_digest_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(negedge clk) begin
		quiet_recv = (sb.words_checked >= 10) && (sb.words_checked < 40);
		pop <= quiet_recv || ($urandom_range(99) >= 24);
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_word(result);
	end

	task send_beat(in_item_t it);
		while (!quiet_send && $urandom_range(99) < 24) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_beat(it);
		if (it.has_byte || it.is_last)
			beats_sent++;
		@(negedge clk);
	endtask

	task send_fields(logic [7:0] data, logic has, logic last);
		in_item_t it;
		it.data_byte = data;
		it.has_byte  = has;
		it.is_last   = last;
		send_beat(it);
	endtask

	task send_message(int unsigned len);
		bit separate_close;
		separate_close = (len == 0) || ($urandom_range(3) == 0);
		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(9) == 0)
				send_fields(8'($urandom), 1'b0, 1'b0);
			send_fields(8'($urandom), 1'b1, (i == len - 1) && !separate_close);
		end
		if (separate_close)
			send_fields(8'($urandom), 1'b0, 1'b1);
		if (len > longest_msg)
			longest_msg = len;
	endtask

	initial begin
		int unsigned edge_lens[10];
		int unsigned msgs;
		int unsigned len;
		int unsigned pick;

		edge_lens = '{55, 56, 57, 63, 64, 65, 119, 120, 0, 1};
		sb = new();
		cycle_count = 0;
		beats_sent = 0;
		longest_msg = 0;
		quiet_send = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		item = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_fields(8'hFF, 1'b0, 1'b1);
		send_fields(8'hFF, 1'b0, 1'b0);
		send_fields(8'h61, 1'b1, 1'b0);
		send_fields(8'h62, 1'b1, 1'b0);
		send_fields(8'h63, 1'b1, 1'b1);
		send_fields(8'hFF, 1'b1, 1'b0);
		send_fields(8'h00, 1'b0, 1'b1);
		send_fields(8'h00, 1'b1, 1'b1);
		send_fields(8'h00, 1'b0, 1'b0);
		send_fields(8'h5A, 1'b1, 1'b0);
		send_fields(8'hFF, 1'b0, 1'b0);
		send_fields(8'hA5, 1'b1, 1'b1);
		send_fields(8'h00, 1'b0, 1'b1);
		send_fields(8'h80, 1'b1, 1'b0);
		send_fields(8'h7F, 1'b1, 1'b1);

		msgs = 0;
		while (beats_sent < ITEM_GOAL || msgs < MSG_GOAL) begin
			quiet_send = (msgs >= 3) && (msgs < 6);
			pick = $urandom_range(9);
			if (pick < 4)
				len = $urandom_range(8);
			else if (pick < 7)
				len = edge_lens[$urandom_range(9)];
			else if (pick < 9)
				len = $urandom_range(40, 9);
			else
				len = $urandom_range(130, 41);
			if (beats_sent + len > ITEM_GOAL)
				len = (beats_sent < ITEM_GOAL) ? ITEM_GOAL - beats_sent : 0;
			send_message(len);
			msgs++;
		end
		quiet_send = 1'b0;
		push <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("tb: %0d byte or close beats, %0d digests, %0d words checked",
			beats_sent, sb.digests_seen, sb.words_checked);
		$display("tb: longest random message %0d bytes, %0d mismatches",
			longest_msg, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/sha1md_pkg.sv
rtl/core/sha1md_front.sv
rtl/core/sha1md_absorb.sv
rtl/core/sha1md_round.sv
rtl/core/sha1md_outq.sv
rtl/core/sha1_message_digest_core.sv
dv/tb_top.sv
